/* design/sptq_pkg.sv */
// Shared types, constants and helpers for the sorted periodic timer queue.
// No dependencies.
package sptq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_FIRE_DEF   = 16;
  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_SET    = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BAD_ID  = 2'd2,
    ST_BAD_TIME = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RA_NONE  = 2'd0,
    RA_DELTA = 2'd1,
    RA_DUE   = 2'd2
  } rearm_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         timer_id;
    logic [63:0]        now_ns;
    logic signed [31:0] value_sec;
    logic signed [31:0] value_nsec;
    logic signed [31:0] period_sec;
    logic signed [31:0] period_nsec;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  result_id;
    logic [1:0]  rearm;
    logic [63:0] next_delta_ns;
    logic        last;
  } out_word_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  timer_id;
    logic [63:0] now_ns;
    logic        bad_time;
    logic        zero_delay;
    logic [31:0] v_sec;
    logic [31:0] v_nsec;
    logic [31:0] p_sec;
    logic [31:0] p_nsec;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_MUL,
    BK_ADD,
    BK_REMOVE,
    BK_INSERT,
    BK_TICK_CHECK,
    BK_RELOAD,
    BK_REPLY
  } bk_state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic time_bad(input logic [31:0] s, input logic [31:0] n);
    return s[31] || (n >= NS_PER_SEC);
  endfunction

endpackage

/* design/sptq_front.sv */
// Front part: accepts commands, checks time fields and queues them.
// Depends on sptq_pkg.
module sptq_front #(
  parameter int QDEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  sptq_pkg::in_word_t in_word,
  output logic            cmd_valid,
  output sptq_pkg::cmd_t  cmd,
  input  logic            cmd_take
);
  import sptq_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t            q [QDEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [PW:0]     cnt;
  cmd_t            c_in;
  logic            push;
  logic            pop;

  assign busy      = (cnt == (PW+1)'(QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt != '0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = q[rp];

  always_comb begin
    c_in.opcode     = in_word.opcode;
    c_in.timer_id   = in_word.timer_id;
    c_in.now_ns     = in_word.now_ns;
    c_in.bad_time   = time_bad(in_word.value_sec, in_word.value_nsec) ||
                      time_bad(in_word.period_sec, in_word.period_nsec);
    c_in.zero_delay = (in_word.value_sec == 0) && (in_word.value_nsec == 0);
    c_in.v_sec      = in_word.value_sec;
    c_in.v_nsec     = in_word.value_nsec;
    c_in.p_sec      = in_word.period_sec;
    c_in.p_nsec     = in_word.period_nsec;
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QDEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(QDEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |=> (cnt <= (PW+1)'(1)))
    else $error("queue count jumped");
  assert property (@(posedge clk) disable iff (rst) cnt <= (PW+1)'(QDEPTH))
    else $error("queue overflow");
endmodule

/* design/sptq_back.sv */
// Back part: timer pool, sorted active queue, and the sequencer that runs commands.
// Depends on sptq_pkg.
module sptq_back #(
  parameter int NUM_TIMERS = sptq_pkg::NUM_TIMERS_DEF,
  parameter int MAX_FIRE   = sptq_pkg::MAX_FIRE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  sptq_pkg::cmd_t   cmd,
  output logic             cmd_take,
  output logic             res_valid,
  output sptq_pkg::out_word_t res
);
  import sptq_pkg::*;

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int FW = $clog2(MAX_FIRE + 1);

  logic [63:0]   deadline [NUM_TIMERS];
  logic [63:0]   period   [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] allocated;
  logic [IW-1:0] order    [NUM_TIMERS];
  logic [CW-1:0] active_count;
  logic [IW-1:0] free_stack [NUM_TIMERS];
  logic [CW-1:0] free_count;

  bk_state_t     state, state_next;
  cmd_t          c;
  logic [IW-1:0] tid;
  logic [63:0]   prod_v, prod_p;
  logic [CW-1:0] pos;
  logic [FW-1:0] fired;
  logic          do_insert;
  logic          id_bad;

  logic          id_ok;
  logic [63:0]   head_dl;
  logic          head_due;
  logic [63:0]   ins_dl;
  logic          ins_stop;
  logic [IW-1:0] free_idx;

  assign id_ok    = ({1'b0, c.timer_id} < 5'(NUM_TIMERS)) && allocated[c.timer_id[IW-1:0]];
  assign head_dl  = deadline[order[0]];
  assign head_due = (active_count != '0) && (head_dl < c.now_ns);
  assign ins_dl   = deadline[order[pos[IW-1:0]]];
  assign ins_stop = (pos == active_count) || (ins_dl > deadline[tid]);
  assign free_idx = IW'(free_count - 1'b1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:       if (cmd_valid) state_next = BK_DISPATCH;
      BK_DISPATCH: begin
        case (opcode_t'(c.opcode))
          OP_CREATE: state_next = BK_IDLE;
          OP_TICK:   state_next = BK_TICK_CHECK;
          OP_DELETE: state_next = id_ok ? BK_REMOVE : BK_REPLY;
          default:   state_next = (!id_ok || c.bad_time) ? BK_REPLY : BK_MUL;
        endcase
      end
      BK_MUL:        state_next = BK_ADD;
      BK_ADD:        state_next = BK_REMOVE;
      BK_REMOVE: begin
        if (pos == active_count) begin
          if (do_insert) state_next = BK_INSERT;
          else state_next = (c.opcode == OP_TICK) ? BK_TICK_CHECK : BK_REPLY;
        end
      end
      BK_INSERT:     if (ins_stop) state_next = (c.opcode == OP_TICK) ? BK_TICK_CHECK : BK_REPLY;
      BK_TICK_CHECK: state_next = (head_due && fired != FW'(MAX_FIRE)) ? BK_RELOAD : BK_REPLY;
      BK_RELOAD:     state_next = BK_REMOVE;
      BK_REPLY:      state_next = BK_IDLE;
      default:       state_next = BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_take  = (state == BK_IDLE);
    res_valid = 1'b0;
    res       = '0;
    if (state == BK_DISPATCH && c.opcode == OP_CREATE) begin
      res_valid = 1'b1;
      res.last  = 1'b1;
      if (free_count == '0) res.status = ST_NO_FREE;
      else res.result_id = 4'(free_stack[free_idx]);
    end else if (state == BK_TICK_CHECK && head_due && fired != FW'(MAX_FIRE)) begin
      res_valid     = 1'b1;
      res.kind      = 1'b1;
      res.result_id = 4'(order[0]);
    end else if (state == BK_REPLY) begin
      res_valid = 1'b1;
      res.last  = 1'b1;
      if (c.opcode != OP_TICK) begin
        res.result_id = c.timer_id;
        if (id_bad) res.status = ST_BAD_ID;
        else if (c.opcode == OP_SET && c.bad_time) res.status = ST_BAD_TIME;
      end
      if (active_count == '0) res.rearm = RA_NONE;
      else if (head_dl > c.now_ns) begin
        res.rearm         = RA_DELTA;
        res.next_delta_ns = head_dl - c.now_ns;
      end else res.rearm = RA_DUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Remove walks one slot a cycle and compacts behind the match; insert
  // walks forward one slot a cycle to find the slot, then, in the same cycle
  // as it writes the new entry, moves the tail up by one place.
  logic found;
  always_ff @(posedge clk) begin
    if (rst) begin
      allocated    <= '0;
      active_count <= '0;
      free_count   <= CW'(NUM_TIMERS);
      for (int i = 0; i < NUM_TIMERS; i++) free_stack[i] <= IW'(NUM_TIMERS - 1 - i);
      found <= 1'b0;
      pos   <= '0;
      fired <= '0;
      do_insert <= 1'b0;
    end else begin
      case (state)
        BK_IDLE: if (cmd_valid) c <= cmd;
        BK_DISPATCH: begin
          tid   <= c.timer_id[IW-1:0];
          pos   <= '0;
          found <= 1'b0;
          fired <= '0;
          id_bad <= !id_ok;
          do_insert <= (c.opcode == OP_SET) && !c.zero_delay;
          if (c.opcode == OP_CREATE && free_count != '0) begin
            free_count <= free_count - 1'b1;
            allocated[free_stack[free_idx]] <= 1'b1;
          end
          if (c.opcode == OP_DELETE && id_ok) begin
            allocated[c.timer_id[IW-1:0]] <= 1'b0;
            free_stack[free_count[IW-1:0]] <= c.timer_id[IW-1:0];
            free_count <= free_count + 1'b1;
          end
        end
        BK_MUL: begin
          prod_v <= 64'(c.v_sec) * 64'(NS_PER_SEC);
          prod_p <= 64'(c.p_sec) * 64'(NS_PER_SEC);
        end
        BK_ADD: begin
          deadline[tid] <= sat_add(c.now_ns, prod_v + 64'(c.v_nsec));
          period[tid]   <= prod_p + 64'(c.p_nsec);
        end
        BK_REMOVE: begin
          if (pos == active_count) begin
            if (found) active_count <= active_count - 1'b1;
            pos <= '0;
          end else begin
            if (found) order[pos[IW-1:0] - 1'b1] <= order[pos[IW-1:0]];
            if (order[pos[IW-1:0]] == tid) found <= 1'b1;
            pos <= pos + 1'b1;
          end
        end
        BK_INSERT: begin
          if (ins_stop) begin
            // Entries from the slot to the tail move up one place together.
            order[pos[IW-1:0]] <= tid;
            for (int i = 1; i < NUM_TIMERS; i++)
              if (CW'(i) > pos && CW'(i) <= active_count) order[i] <= order[i-1];
            active_count <= active_count + 1'b1;
            found <= 1'b0;
            pos   <= '0;
          end else pos <= pos + 1'b1;
        end
        BK_TICK_CHECK: begin
          if (head_due && fired != FW'(MAX_FIRE)) begin
            tid   <= order[0];
            fired <= fired + 1'b1;
          end
        end
        BK_RELOAD: begin
          deadline[tid] <= sat_add(deadline[tid], period[tid]);
          do_insert <= (period[tid] != '0);
          pos   <= '0;
          found <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) active_count <= CW'(NUM_TIMERS))
    else $error("active count overflow");
  assert property (@(posedge clk) disable iff (rst) free_count <= CW'(NUM_TIMERS))
    else $error("free count overflow");
  assert property (@(posedge clk) disable iff (rst) res_valid && res.kind |-> !res.last)
    else $error("expiry marked last");
  assert property (@(posedge clk) disable iff (rst) fired <= FW'(MAX_FIRE))
    else $error("fire cap exceeded");
endmodule

/* design/sorted_periodic_timer_queue.sv */
// Interval timer pool with a deadline-sorted active queue (top level).
// Create answers in its dispatch state; delete/set/tick walk the queue one slot a cycle,
// and each expiry in a tick walks it again to remove and, if periodic, reinsert the timer.
// One command is worked on at a time in the back part; a two-entry command
// queue lets start be taken while it works. Results cannot be stalled.
// Reset (rst, synchronous) frees all timers and empties the active queue.
module sorted_periodic_timer_queue #(
  parameter int NUM_TIMERS = sptq_pkg::NUM_TIMERS_DEF,
  parameter int MAX_FIRE   = sptq_pkg::MAX_FIRE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sptq_pkg::in_word_t  in_word,
  output logic                strobe,
  output sptq_pkg::out_word_t out_word
);
  import sptq_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  sptq_front #(.QDEPTH(2)) u_front (
    .clk, .rst, .start, .busy, .in_word, .cmd_valid, .cmd, .cmd_take
  );

  sptq_back #(.NUM_TIMERS(NUM_TIMERS), .MAX_FIRE(MAX_FIRE)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .res_valid(strobe), .res(out_word)
  );
endmodule

/* verif/sorted_periodic_timer_queue_test.sv */
// Self-checking testbench for the sorted periodic timer queue.
// Uses sptq_pkg types; holds its own timer pool model to predict each result word.
`timescale 1ns / 1ps

module sorted_periodic_timer_queue_test;
  import sptq_pkg::*;

  localparam int NT = 16;
  localparam int FIRE_CAP = 16;

  typedef struct {
    in_word_t w;
    bit       drain;
  } cmd_item_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      strobe;
  out_word_t out_word;

  sorted_periodic_timer_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .strobe(strobe), .out_word(out_word)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  cmd_item_t pending_cmds[$];
  out_word_t expected_words[$];
  int        errors = 0;
  int        accepted = 0;

  // Shadow of the timer pool.
  logic [63:0] sh_deadline[NT];
  logic [63:0] sh_period[NT];
  bit          sh_alloc[NT];
  logic [3:0]  sh_order[NT];
  int          sh_active;
  logic [3:0]  sh_free[NT];
  int          sh_free_cnt;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // 1 legal nonzero, 0 zero, -1 illegal.
  function automatic int classify_time(logic [31:0] s, logic [31:0] n);
    if (s[31] || n >= 32'd1000000000) return -1;
    return (s == 0 && n == 0) ? 0 : 1;
  endfunction

  function automatic logic [63:0] span_ns(logic [31:0] s, logic [31:0] n);
    return {32'd0, s} * 64'd1000000000 + {32'd0, n};
  endfunction

  function automatic void unlink_timer(int t);
    int j;
    for (j = 0; j < sh_active; j++) begin
      if (sh_order[j] == t) begin
        for (; j + 1 < sh_active; j++) sh_order[j] = sh_order[j + 1];
        sh_active--;
        return;
      end
    end
  endfunction

  function automatic void link_timer(int t);
    int j;
    j = 0;
    if (sh_active >= NT) return;
    while (j < sh_active && sh_deadline[sh_order[j]] <= sh_deadline[t]) j++;
    for (int k = sh_active; k > j; k--) sh_order[k] = sh_order[k - 1];
    sh_order[j] = t[3:0];
    sh_active++;
  endfunction

  function automatic out_word_t make_word(logic kind, status_t st, logic [3:0] id,
                                          rearm_t ra, logic [63:0] d, logic lst);
    out_word_t o;
    o.kind = kind;
    o.status = st;
    o.result_id = id;
    o.rearm = ra;
    o.next_delta_ns = d;
    o.last = lst;
    return o;
  endfunction

  function automatic out_word_t reply_word(status_t st, logic [3:0] id, logic [63:0] now);
    logic [63:0] head;
    if (sh_active == 0) return make_word(1'b0, st, id, RA_NONE, 64'd0, 1'b1);
    head = sh_deadline[sh_order[0]];
    if (head > now) return make_word(1'b0, st, id, RA_DELTA, head - now, 1'b1);
    return make_word(1'b0, st, id, RA_DUE, 64'd0, 1'b1);
  endfunction

  function automatic void predict_timer_op(in_word_t w);
    int t, v, p, n;
    logic [63:0] now;
    now = w.now_ns;
    t = w.timer_id;
    case (opcode_t'(w.opcode))
      OP_CREATE: begin
        if (sh_free_cnt == 0) begin
          expected_words.push_back(make_word(1'b0, ST_NO_FREE, 4'd0, RA_NONE, 64'd0, 1'b1));
        end else begin
          sh_free_cnt--;
          t = sh_free[sh_free_cnt];
          sh_alloc[t] = 1;
          expected_words.push_back(make_word(1'b0, ST_OK, t[3:0], RA_NONE, 64'd0, 1'b1));
        end
      end
      OP_TICK: begin
        n = 0;
        while (n < FIRE_CAP && sh_active > 0 && sh_deadline[sh_order[0]] < now) begin
          t = sh_order[0];
          unlink_timer(t);
          if (sh_period[t] != 0) begin
            sh_deadline[t] = add_sat(sh_deadline[t], sh_period[t]);
            link_timer(t);
          end
          expected_words.push_back(make_word(1'b1, ST_OK, t[3:0], RA_NONE, 64'd0, 1'b0));
          n++;
        end
        expected_words.push_back(reply_word(ST_OK, 4'd0, now));
      end
      OP_DELETE: begin
        if (!sh_alloc[t]) begin
          expected_words.push_back(reply_word(ST_BAD_ID, w.timer_id, now));
        end else begin
          unlink_timer(t);
          sh_alloc[t] = 0;
          if (sh_free_cnt < NT) begin
            sh_free[sh_free_cnt] = t[3:0];
            sh_free_cnt++;
          end
          expected_words.push_back(reply_word(ST_OK, w.timer_id, now));
        end
      end
      default: begin
        if (!sh_alloc[t]) begin
          expected_words.push_back(reply_word(ST_BAD_ID, w.timer_id, now));
        end else begin
          v = classify_time(w.value_sec, w.value_nsec);
          p = classify_time(w.period_sec, w.period_nsec);
          if (v < 0 || p < 0) begin
            expected_words.push_back(reply_word(ST_BAD_TIME, w.timer_id, now));
          end else begin
            unlink_timer(t);
            if (v > 0) begin
              sh_deadline[t] = add_sat(now, span_ns(w.value_sec, w.value_nsec));
              sh_period[t] = span_ns(w.period_sec, w.period_nsec);
              link_timer(t);
            end
            expected_words.push_back(reply_word(ST_OK, w.timer_id, now));
          end
        end
      end
    endcase
  endfunction

  // Driver: start stays high until the word is taken.
  always @(posedge clk) begin
    int idle_pct;
    if (rst) begin
      start <= 1'b0;
      in_word <= '0;
    end else begin
      if (start && !busy) begin
        predict_timer_op(in_word);
        void'(pending_cmds.pop_front());
        accepted++;
      end
      idle_pct = (accepted < 35) ? 23 : (accepted < 70) ? 68 : 0;
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 &&
            !(pending_cmds[0].drain && expected_words.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_word <= pending_cmds[0].w;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_word);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word.kind !== exp_w.kind || out_word.status !== exp_w.status ||
            out_word.result_id !== exp_w.result_id || out_word.rearm !== exp_w.rearm ||
            out_word.next_delta_ns !== exp_w.next_delta_ns ||
            out_word.last !== exp_w.last) begin
          $display("%0t: mismatch expected kind=%0d st=%0d id=%0d ra=%0d d=%0d last=%0d",
                   $time, exp_w.kind, exp_w.status, exp_w.result_id, exp_w.rearm,
                   exp_w.next_delta_ns, exp_w.last);
          $display("%0t:          actual   kind=%0d st=%0d id=%0d ra=%0d d=%0d last=%0d",
                   $time, out_word.kind, out_word.status, out_word.result_id,
                   out_word.rearm, out_word.next_delta_ns, out_word.last);
          errors++;
        end
      end
    end
  end

  function automatic void queue_cmd(opcode_t op, int id, logic [63:0] now,
                                    logic [31:0] vs, logic [31:0] vn,
                                    logic [31:0] ps, logic [31:0] pn, bit drain);
    cmd_item_t c;
    c.w.opcode = op;
    c.w.timer_id = id[3:0];
    c.w.now_ns = now;
    c.w.value_sec = vs;
    c.w.value_nsec = vn;
    c.w.period_sec = ps;
    c.w.period_nsec = pn;
    c.drain = drain;
    pending_cmds.push_back(c);
  endfunction

  initial begin
    logic [63:0] clock_ns;
    logic [31:0] vs, vn, ps, pn;
    int r;
    rst = 1'b1;
    for (int i = 0; i < NT; i++) begin
      sh_alloc[i] = 0;
      sh_deadline[i] = 0;
      sh_period[i] = 0;
      sh_order[i] = 0;
      sh_free[i] = NT - 1 - i;
    end
    sh_active = 0;
    sh_free_cnt = NT;

    // Directed: exhaust the pool, bad ids, illegal times, zero delay, saturation.
    for (int i = 0; i < 17; i++) queue_cmd(OP_CREATE, 0, 64'd0, 0, 0, 0, 0, 0);
    queue_cmd(OP_DELETE, 3, 64'd5, 0, 0, 0, 0, 0);
    queue_cmd(OP_DELETE, 3, 64'd5, 0, 0, 0, 0, 0);
    queue_cmd(OP_SET, 3, 64'd5, 0, 7, 0, 0, 0);
    queue_cmd(OP_SET, 1, 64'd5, 32'h8000_0000, 7, 0, 0, 0);
    queue_cmd(OP_SET, 1, 64'd5, 0, 32'd1000000000, 0, 0, 0);
    queue_cmd(OP_SET, 1, 64'd5, 0, 7, 0, 32'hFFFF_FFFF, 0);
    queue_cmd(OP_SET, 1, 64'hFFFF_FFFF_FFFF_FFF0, 32'h7FFF_FFFF, 32'd999999999,
              32'h7FFF_FFFF, 32'd999999999, 0);
    queue_cmd(OP_TICK, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
    queue_cmd(OP_SET, 1, 64'd9, 0, 0, 0, 5, 0);
    queue_cmd(OP_CREATE, 0, 64'd9, 0, 0, 0, 0, 0);

    // Arm every allocated timer with tied, reloading deadlines, then overrun the cap.
    for (int i = 0; i < NT; i++) queue_cmd(OP_SET, i, 64'd10, 0, 20 + (i % 2), 0, 1, 0);
    queue_cmd(OP_TICK, 0, 64'd100, 0, 0, 0, 0, 0);
    queue_cmd(OP_TICK, 0, 64'd100, 0, 0, 0, 0, 1);

    clock_ns = 64'd200;
    for (int i = 0; i < 60; i++) begin
      clock_ns = clock_ns + $urandom_range(2000000000);
      r = $urandom_range(99);
      vs = $urandom_range(2);
      vn = $urandom_range(999999999);
      ps = ($urandom_range(1) == 0) ? 32'd0 : $urandom_range(1);
      pn = $urandom_range(999999999);
      if ($urandom_range(99) < 10) begin
        vs = $urandom;
        vn = $urandom;
        ps = $urandom;
        pn = $urandom;
      end
      if ($urandom_range(99) < 5) clock_ns = {$urandom, $urandom};
      queue_cmd(r < 20 ? OP_CREATE : r < 35 ? OP_DELETE : r < 72 ? OP_SET : OP_TICK,
                $urandom_range(NT - 1), clock_ns, vs, vn, ps, pn, (i == 40));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
